// File: sv/proportional_heater_control_defines.svh
// ---------------------------------------------------------------------------
// proportional_heater_control_defines
// Assertion macros shared by the heater controller checker.
// ---------------------------------------------------------------------------
`ifndef PROPORTIONAL_HEATER_CONTROL_DEFINES_SVH
`define PROPORTIONAL_HEATER_CONTROL_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PHC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heater controller check failed");

// next-cycle implication, sampled on clk, off during reset
`define PHC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heater controller check failed");

`endif

// File: sv/phc_pkg.sv
// ---------------------------------------------------------------------------
// phc_pkg
// Types, register codes and constants of the proportional heater controller.
// ---------------------------------------------------------------------------
package phc_pkg;

    localparam int TEMP_W   = 12;
    localparam int TGT_W    = 10;
    localparam int GAIN_W   = 10;
    localparam int DB_W     = 6;
    localparam int DUTY_W   = 7;
    localparam int ERR_W    = 13;
    localparam int PROD_W   = 24;
    localparam int MEAN_W   = 12;
    localparam int CNT32_W  = 32;
    localparam int ACC_W    = 45;
    localparam int STEP_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEILING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_ENABLE  = 3'd5;

    // register reset values
    localparam logic [TGT_W-1:0]  RST_TARGET_TEMP  = 10'd80;
    localparam logic [GAIN_W-1:0] RST_GAIN         = 10'd320;
    localparam logic [DB_W-1:0]   RST_DEAD_BAND    = 6'd5;
    localparam logic [DUTY_W-1:0] RST_DUTY_CEILING = 7'd80;
    localparam logic [DUTY_W-1:0] RST_DUTY_FLOOR   = 7'd0;

    // status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SENSOR   = 2'd1;
    localparam logic [1:0] STATUS_DISABLED = 2'd2;

    // heat levels and their duty thresholds
    localparam logic [1:0] LVL_OFF  = 2'd0;
    localparam logic [1:0] LVL_LOW  = 2'd1;
    localparam logic [1:0] LVL_MED  = 2'd2;
    localparam logic [1:0] LVL_HIGH = 2'd3;
    localparam logic [DUTY_W-1:0] DUTY_HIGH_MIN = 7'd75;
    localparam logic [DUTY_W-1:0] DUTY_MED_MIN  = 7'd50;
    localparam logic [DUTY_W-1:0] DUTY_LOW_MIN  = 7'd25;

    localparam logic [CNT32_W-1:0] CNT_MAX = {CNT32_W{1'b1}};

    typedef struct packed {
        logic [TGT_W-1:0]  target_temp;
        logic [GAIN_W-1:0] gain;
        logic [DB_W-1:0]   dead_band;
        logic [DUTY_W-1:0] duty_ceiling;
        logic [DUTY_W-1:0] duty_floor;
        logic              prop_enable;
    } cfg_t;

endpackage

// File: sv/phc_addsub.sv
// ---------------------------------------------------------------------------
// phc_addsub
// Shared 45-bit adder/subtractor used for shift-add multiply and division.
// ---------------------------------------------------------------------------
module phc_addsub
    import phc_pkg::*;
(
    input  logic [ACC_W-1:0] a,
    input  logic [ACC_W-1:0] b,
    input  logic             sub,
    output logic [ACC_W-1:0] sum,
    output logic             carry
);

    logic [ACC_W-1:0] b_eff;

    assign b_eff = sub ? ~b : b;

    // on subtract, carry set means a >= b
    assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + {{ACC_W{1'b0}}, sub};

endmodule

// File: sv/phc_cfg.sv
// ---------------------------------------------------------------------------
// phc_cfg
// Configuration register file of the heater controller.
// ---------------------------------------------------------------------------
module phc_cfg
    import phc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET_TEMP:  cfg_next.target_temp  = cfg_data[TGT_W-1:0];
                REG_GAIN:         cfg_next.gain         = cfg_data[GAIN_W-1:0];
                REG_DEAD_BAND:    cfg_next.dead_band    = cfg_data[DB_W-1:0];
                REG_DUTY_CEILING: cfg_next.duty_ceiling = cfg_data[DUTY_W-1:0];
                REG_DUTY_FLOOR:   cfg_next.duty_floor   = cfg_data[DUTY_W-1:0];
                REG_PROP_ENABLE:  cfg_next.prop_enable  = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_temp  <= RST_TARGET_TEMP;
            cfg_reg.gain         <= RST_GAIN;
            cfg_reg.dead_band    <= RST_DEAD_BAND;
            cfg_reg.duty_ceiling <= RST_DUTY_CEILING;
            cfg_reg.duty_floor   <= RST_DUTY_FLOOR;
            cfg_reg.prop_enable  <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/proportional_heater_control.sv
// A sample update runs evaluation, duty, the 12-step mean multiply, the mean add,
// the 12-step divide and done before out_valid; a clear command, a failed reading
// or disabled mode goes from evaluation straight to done. One request at a time,
// with the mean work done on the single shared 45-bit adder.
// Reset: registers take their defaults, statistics and heater state go to zero.
// ---------------------------------------------------------------------------
// proportional_heater_control
// Proportional heater controller with dead zone and running error statistics.
// ---------------------------------------------------------------------------
module proportional_heater_control
    import phc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  command,
    input  logic signed [TEMP_W-1:0] temperature,
    input  logic                  sensor_ok,
    input  logic [CNT32_W-1:0]    now_ms,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [DUTY_W-1:0]     duty,
    output logic [1:0]            heat_level,
    output logic                  booster_on,
    output logic [MEAN_W-1:0]     mean_error,
    output logic [MEAN_W-1:0]     peak_error,
    output logic [CNT32_W-1:0]    update_count,
    output logic [CNT32_W-1:0]    heat_time_ms,
    output logic [CNT32_W-1:0]    heat_cycles
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DUTY = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ADDM = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MEAN_W - 1);

    cfg_t cfg;

    logic [2:0] state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    // captured request
    logic cmd_reg, ok_reg;
    logic [TEMP_W-1:0]  temp_reg;
    logic [CNT32_W-1:0] now_reg;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [MEAN_W-1:0] mag_reg, mag_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [DUTY_W-1:0] res_duty_reg, res_duty_next;

    // controller state and statistics
    logic              booster_reg, booster_next;
    logic [1:0]        level_reg, level_next;
    logic [CNT32_W-1:0] updates_reg, updates_next;
    logic [MEAN_W-1:0] mean_reg, mean_next;
    logic [MEAN_W-1:0] peak_reg, peak_next;
    logic [CNT32_W-1:0] heated_reg, heated_next;
    logic [CNT32_W-1:0] cycles_reg, cycles_next;
    logic [CNT32_W-1:0] prior_reg, prior_next;

    // mean update datapath
    logic [CNT32_W-1:0] nm1_reg, nm1_next;
    logic [CNT32_W-1:0] n_reg, n_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [CNT32_W-1:0] rem_reg, rem_next;
    logic [MEAN_W-1:0]  dq_reg, dq_next;

    logic out_valid_reg, out_valid_next;
    logic out_load;

    logic [1:0]         q_status_reg;
    logic [DUTY_W-1:0]  q_duty_reg;
    logic [1:0]         q_level_reg;
    logic               q_booster_reg;
    logic [MEAN_W-1:0]  q_mean_reg;
    logic [MEAN_W-1:0]  q_peak_reg;
    logic [CNT32_W-1:0] q_updates_reg;
    logic [CNT32_W-1:0] q_heated_reg;
    logic [CNT32_W-1:0] q_cycles_reg;

    // shared unit
    logic [ACC_W-1:0] alu_a, alu_b, alu_sum;
    logic             alu_sub, alu_carry;

    // control law
    logic signed [ERR_W-1:0]  err_c, err_dz;
    logic [ERR_W-1:0]         mag_raw;
    logic                     in_dead;
    logic signed [PROD_W-1:0] prod_c, floor_s, ceil_s, clamp_lo, clamp_hi;
    logic [DUTY_W-1:0]        duty_c;
    logic [1:0]               level_c;
    logic [STEP_W-1:0]        mbit_idx;

    phc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    phc_addsub u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    // error and dead zone
    assign err_c   = ERR_W'($signed(cfg.target_temp)) - ERR_W'($signed(temp_reg));
    assign mag_raw = err_c[ERR_W-1] ? ERR_W'(-err_c) : ERR_W'(err_c);
    assign in_dead = mag_raw < ERR_W'(cfg.dead_band);
    assign err_dz  = in_dead ? '0 : err_c;
    assign prod_c  = $signed({1'b0, cfg.gain}) * err_dz;

    // floor first, then ceiling
    assign floor_s  = $signed({{(PROD_W-DUTY_W-8){1'b0}}, cfg.duty_floor, 8'd0});
    assign ceil_s   = $signed({{(PROD_W-DUTY_W-8){1'b0}}, cfg.duty_ceiling, 8'd0});
    assign clamp_lo = (prod_reg < floor_s) ? floor_s : prod_reg;
    assign clamp_hi = (clamp_lo > ceil_s) ? ceil_s : clamp_lo;
    assign duty_c   = clamp_hi[DUTY_W+7:8];

    always_comb
    begin
        if (duty_c > DUTY_HIGH_MIN)
            level_c = LVL_HIGH;
        else if (duty_c > DUTY_MED_MIN)
            level_c = LVL_MED;
        else if (duty_c > DUTY_LOW_MIN)
            level_c = LVL_LOW;
        else
            level_c = LVL_OFF;
    end

    // multiply walks the old mean msb first
    assign mbit_idx = LAST_STEP - cnt_reg;

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        prod_next       = prod_reg;
        mag_next        = mag_reg;
        res_status_next = res_status_reg;
        res_duty_next   = res_duty_reg;
        booster_next    = booster_reg;
        level_next      = level_reg;
        updates_next    = updates_reg;
        mean_next       = mean_reg;
        peak_next       = peak_reg;
        heated_next     = heated_reg;
        cycles_next     = cycles_reg;
        prior_next      = prior_reg;
        nm1_next        = nm1_reg;
        n_next          = n_reg;
        acc_next        = acc_reg;
        rem_next        = rem_reg;
        dq_next         = dq_reg;
        out_valid_next  = out_valid_reg;
        alu_a           = '0;
        alu_b           = '0;
        alu_sub         = 1'b0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                res_duty_next   = '0;
                res_status_next = STATUS_OK;
                if (cmd_reg)
                begin
                    updates_next = '0;
                    mean_next    = '0;
                    peak_next    = '0;
                    heated_next  = '0;
                    cycles_next  = '0;
                    state_next   = S_DONE;
                end
                else if (!ok_reg)
                begin
                    res_status_next = STATUS_SENSOR;
                    state_next      = S_DONE;
                end
                else if (!cfg.prop_enable)
                begin
                    res_status_next = STATUS_DISABLED;
                    state_next      = S_DONE;
                end
                else
                begin
                    prod_next  = prod_c;
                    mag_next   = mag_raw[MEAN_W-1:0] & {MEAN_W{!in_dead}};
                    state_next = S_DUTY;
                end
            end
            S_DUTY:
            begin
                res_duty_next = duty_c;
                if (duty_c != '0)
                begin
                    booster_next = 1'b1;
                    // heater start only from fully off
                    if (!booster_reg && level_reg == LVL_OFF)
                        cycles_next = cycles_reg + 1'b1;
                end
                else
                begin
                    booster_next = 1'b0;
                end
                level_next = level_c;
                if (updates_reg == CNT_MAX)
                begin
                    nm1_next = CNT_MAX - 1'b1;
                    n_next   = CNT_MAX;
                end
                else
                begin
                    nm1_next     = updates_reg;
                    n_next       = updates_reg + 1'b1;
                    updates_next = updates_reg + 1'b1;
                end
                if (mag_reg > peak_reg)
                    peak_next = mag_reg;
                acc_next   = '0;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                alu_a    = {acc_reg[ACC_W-2:0], 1'b0};
                alu_b    = mean_reg[mbit_idx] ? ACC_W'(nm1_reg) : '0;
                acc_next = alu_sum;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                    state_next = S_ADDM;
            end
            S_ADDM:
            begin
                alu_a = acc_reg;
                alu_b = ACC_W'(mag_reg);
                // quotient fits the mean width, so the top part is already below n
                rem_next = alu_sum[MEAN_W+CNT32_W-1:MEAN_W];
                dq_next  = alu_sum[MEAN_W-1:0];
                cnt_next = '0;
                if (prior_reg != '0 && level_reg != LVL_OFF)
                    heated_next = heated_reg + (now_reg - prior_reg);
                prior_next = now_reg;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                alu_a   = ACC_W'({rem_reg, dq_reg[MEAN_W-1]});
                alu_b   = ACC_W'(n_reg);
                alu_sub = 1'b1;
                if (alu_carry)
                    rem_next = alu_sum[CNT32_W-1:0];
                else
                    rem_next = {rem_reg[CNT32_W-2:0], dq_reg[MEAN_W-1]};
                dq_next  = {dq_reg[MEAN_W-2:0], alu_carry};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    mean_next  = {dq_reg[MEAN_W-2:0], alu_carry};
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            booster_reg   <= 1'b0;
            level_reg     <= LVL_OFF;
            updates_reg   <= '0;
            mean_reg      <= '0;
            peak_reg      <= '0;
            heated_reg    <= '0;
            cycles_reg    <= '0;
            prior_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            booster_reg   <= booster_next;
            level_reg     <= level_next;
            updates_reg   <= updates_next;
            mean_reg      <= mean_next;
            peak_reg      <= peak_next;
            heated_reg    <= heated_next;
            cycles_reg    <= cycles_next;
            prior_reg     <= prior_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            cmd_reg  <= command;
            temp_reg <= temperature;
            ok_reg   <= sensor_ok;
            now_reg  <= now_ms;
        end
        prod_reg       <= prod_next;
        mag_reg        <= mag_next;
        res_status_reg <= res_status_next;
        res_duty_reg   <= res_duty_next;
        nm1_reg        <= nm1_next;
        n_reg          <= n_next;
        acc_reg        <= acc_next;
        rem_reg        <= rem_next;
        dq_reg         <= dq_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            q_status_reg  <= res_status_reg;
            q_duty_reg    <= res_duty_reg;
            q_level_reg   <= level_reg;
            q_booster_reg <= booster_reg;
            q_mean_reg    <= mean_reg;
            q_peak_reg    <= peak_reg;
            q_updates_reg <= updates_reg;
            q_heated_reg  <= heated_reg;
            q_cycles_reg  <= cycles_reg;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = q_status_reg;
    assign duty         = q_duty_reg;
    assign heat_level   = q_level_reg;
    assign booster_on   = q_booster_reg;
    assign mean_error   = q_mean_reg;
    assign peak_error   = q_peak_reg;
    assign update_count = q_updates_reg;
    assign heat_time_ms = q_heated_reg;
    assign heat_cycles  = q_cycles_reg;

endmodule

// File: sv/phc_checker.sv
// ---------------------------------------------------------------------------
// phc_checker
// Port-level checks of the heater controller, bound to the top level.
// ---------------------------------------------------------------------------
`include "proportional_heater_control_defines.svh"

module phc_checker
    import phc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [1:0]        status,
    input logic [DUTY_W-1:0] duty,
    input logic [1:0]        heat_level,
    input logic              booster_on
);

    // one request in flight: the input side closes right after a request
    `PHC_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)

    // a waiting result stays put
    `PHC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(duty))

    // only a normal update produces duty
    `PHC_ASSERT_NOW(a_fault_no_duty, out_valid && status != STATUS_OK, duty == '0)

    // a heater level needs the booster, and high duty means high level
    `PHC_ASSERT_NOW(a_level_boost, out_valid && heat_level != LVL_OFF, booster_on)
    `PHC_ASSERT_NOW(a_high_level, out_valid && duty > DUTY_HIGH_MIN, heat_level == LVL_HIGH)

endmodule

bind proportional_heater_control phc_checker u_phc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .duty       (duty),
    .heat_level (heat_level),
    .booster_on (booster_on)
);
